### rtl/scrp_pkg.sv
package scrp_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned STEP_W    = 33;
  localparam int unsigned SPD_OUT_W = 14;
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned OUT_W     = 72;

  localparam logic [CFG_W-1:0] RAMP_RESET = 16'd200;
  localparam logic [CFG_W-1:0] MINP_RESET = 16'd499;
  localparam logic [CFG_W-1:0] MAXP_RESET = 16'd19999;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] LOW32  = 64'h00000000FFFFFFFF;
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;
  localparam logic [63:0] TERM_DIV [13] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                            64'd156, 64'd210, 64'd272, 64'd342,
                                            64'd420, 64'd506, 64'd600, 64'd702};

  typedef enum logic [1:0] {
    REQ_MOVE   = 2'd0,
    REQ_PULSE  = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_PRESET = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PH_STOP   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CFG_RAMP = 2'd0,
    CFG_MINP = 2'd1,
    CFG_MAXP = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDX,
    ST_IDXW,
    ST_ROM,
    ST_SPD,
    ST_MUL,
    ST_REL,
    ST_RELW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic apply;
    logic div_idx;
    logic div_rel;
    logic spd_load;
    logic mul;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_lookup;
    logic div_busy;
  } dp_sts_t;

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [15:0] tab_entry(int unsigned i, int unsigned pb,
                                            int unsigned sf);
    logic [63:0] ph;
    logic [63:0] pl;
    logic [63:0] ii;
    logic [63:0] sfl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] s2;
    logic [63:0] v;
    int unsigned sh;
    sh   = pb + 1;
    ph   = PI_Q60 >> 32;
    pl   = PI_Q60 & LOW32;
    ii   = 64'(i);
    sfl  = 64'(sf);
    x    = ((ph * ii) << (32 - sh)) + ((pl * ii) >> sh);
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 13; n++) begin
      term = mul_q60(term, x2) / TERM_DIV[n-1];
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    s2 = mul_q60(sum, sum);
    if (s2 > ONE_Q60) s2 = ONE_Q60;
    v = ((sfl * (s2 >> 32)) << 12) + ((sfl * (s2 & LOW32)) >> 20);
    v = (v + 64'd256) >> 40;
    if (v > sfl) v = sfl;
    return v[15:0];
  endfunction

endpackage

### rtl/stepper_cosine_ramp_profiler_core.sv
// An item that needs a ramp speed passes the 32-step index divider and the table read
//   on its way from input transfer to result; every other item skips both.
// One item at a time: a new input is taken only once the last item has left the output
//   state; a result not yet taken holds the next one in the output state.
// A finished result waits in the output register while the next item is taken.
// Reset: synchronous, active low; registers 200/499/19999, position zero, direction up.
module stepper_cosine_ramp_profiler_core #(
  parameter int unsigned PHASE_BITS = 10,
  parameter int unsigned SPEED_FULL = 10000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // position_value
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // status, position, phase, direction, speed,
                                  // reload_period, pulse_enable
);

  scrp_pkg::dp_cmd_t cmd;
  scrp_pkg::dp_sts_t sts;

  scrp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  scrp_dp #(
    .PHASE_BITS (PHASE_BITS),
    .SPEED_FULL (SPEED_FULL)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_tuser),
    .in_pos    (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

### rtl/scrp_div.sv
module scrp_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [scrp_pkg::DIV_W-1:0]     dividend,
  input  logic [scrp_pkg::CFG_W-1:0]     divisor,
  output logic                           busy,
  output logic [scrp_pkg::DIV_W-1:0]     quotient
);

  localparam int unsigned CW = $clog2(scrp_pkg::DIV_W);

  logic [scrp_pkg::CFG_W-1:0] rem_r, rem_nxt;
  logic [scrp_pkg::CFG_W-1:0] dvs_r, dvs_nxt;
  logic [scrp_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic [scrp_pkg::CFG_W:0]   shifted;
  logic [scrp_pkg::CFG_W+1:0] trial;

  always_comb begin
    shifted  = {rem_r, quo_r[scrp_pkg::DIV_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs_r};
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(scrp_pkg::DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[scrp_pkg::CFG_W+1]) begin
        rem_nxt = trial[scrp_pkg::CFG_W-1:0];
        quo_nxt = {quo_r[scrp_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[scrp_pkg::CFG_W-1:0];
        quo_nxt = {quo_r[scrp_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### rtl/scrp_rom.sv
module scrp_rom #(
  parameter int unsigned PHASE_BITS = 10,
  parameter int unsigned SPEED_FULL = 10000
) (
  input  logic                                clk,
  input  logic [PHASE_BITS:0]                 addr,
  output logic [$clog2(SPEED_FULL+1)-1:0]     data
);

  localparam int unsigned TAB_LEN = (1 << PHASE_BITS) + 1;
  localparam int unsigned SPD_W   = $clog2(SPEED_FULL + 1);

  typedef logic [SPD_W-1:0] tab_arr_t [TAB_LEN];

  function automatic tab_arr_t build_tab();
    tab_arr_t t;
    for (int unsigned i = 0; i < TAB_LEN; i++) begin
      t[i] = SPD_W'(scrp_pkg::tab_entry(i, PHASE_BITS, SPEED_FULL));
    end
    return t;
  endfunction

  localparam tab_arr_t TAB = build_tab();

  logic [SPD_W-1:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= TAB[addr];
  end

  assign data = data_r;

endmodule

### rtl/scrp_ctrl.sv
module scrp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  scrp_pkg::dp_sts_t sts,
  output scrp_pkg::dp_cmd_t cmd
);

  scrp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scrp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    case (state_r)
      scrp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.apply = 1'b1;
          state_nxt = scrp_pkg::ST_IDX;
        end
      end
      scrp_pkg::ST_IDX: begin
        if (sts.need_lookup) begin
          cmd.div_idx = 1'b1;
          state_nxt   = scrp_pkg::ST_IDXW;
        end else begin
          state_nxt = scrp_pkg::ST_MUL;
        end
      end
      scrp_pkg::ST_IDXW: begin
        if (!sts.div_busy) state_nxt = scrp_pkg::ST_ROM;
      end
      scrp_pkg::ST_ROM: begin
        state_nxt = scrp_pkg::ST_SPD;
      end
      scrp_pkg::ST_SPD: begin
        cmd.spd_load = 1'b1;
        state_nxt    = scrp_pkg::ST_MUL;
      end
      scrp_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = scrp_pkg::ST_REL;
      end
      scrp_pkg::ST_REL: begin
        cmd.div_rel = 1'b1;
        state_nxt   = scrp_pkg::ST_RELW;
      end
      scrp_pkg::ST_RELW: begin
        if (!sts.div_busy) state_nxt = scrp_pkg::ST_OUT;
      end
      scrp_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = scrp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scrp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

### rtl/scrp_dp.sv
module scrp_dp #(
  parameter int unsigned PHASE_BITS = 10,
  parameter int unsigned SPEED_FULL = 10000
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [scrp_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [1:0]                      in_req,
  input  logic [scrp_pkg::POS_W-1:0]      in_pos,
  input  scrp_pkg::dp_cmd_t               cmd,
  output scrp_pkg::dp_sts_t               sts,
  output logic [scrp_pkg::OUT_W-1:0]      out_tdata
);

  localparam int unsigned SPD_W = $clog2(SPEED_FULL + 1);
  localparam int unsigned AW    = PHASE_BITS + 1;
  localparam int unsigned PW    = scrp_pkg::POS_W;
  localparam int unsigned CW    = scrp_pkg::CFG_W;
  localparam int unsigned SW    = scrp_pkg::STEP_W;
  localparam logic [scrp_pkg::DIV_W-1:0] IDX_MAX = scrp_pkg::DIV_W'(1 << PHASE_BITS);
  localparam int unsigned PROD_W = CW + SPD_W;
  localparam int unsigned RSH    = PROD_W + SPD_W;
  localparam logic [RSH:0] RECIP_FULL =
    ({1'b1, {RSH{1'b0}}} + (RSH+1)'(SPEED_FULL - 1)) / (RSH+1)'(SPEED_FULL);
  localparam logic [PROD_W+1:0] RECIP = RECIP_FULL[PROD_W+1:0];

  logic [CW-1:0]     ramp_r, minp_r, maxp_r;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     tgt_r, tgt_nxt;
  logic              dir_r, dir_nxt;
  scrp_pkg::phase_t  ph_r, ph_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [CW-1:0]     acc_r, acc_nxt;
  logic [PW-1:0]     cru_r, cru_nxt;
  logic [CW-1:0]     dec_r, dec_nxt;
  logic [SPD_W-1:0]  spd_r, spd_nxt;
  logic              stat_r, stat_nxt;
  logic              need_r, need_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [CW-1:0]     rel_q_r;
  logic [scrp_pkg::OUT_W-1:0] out_r;

  logic [PW-1:0]     move_len;
  logic [CW:0]       n2;
  logic [PW:0]       d33;
  logic [PW:0]       dabs;
  logic [CW-1:0]     diff;
  logic [CW-1:0]     reload;
  logic [2*PROD_W+1:0] rel_prod;
  logic              div_start;
  logic [scrp_pkg::DIV_W-1:0] div_dvd;
  logic [CW-1:0]     div_dvs;
  logic              div_busy;
  logic [scrp_pkg::DIV_W-1:0] div_q;
  logic [AW-1:0]     rom_addr;
  logic [SPD_W-1:0]  rom_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r <= scrp_pkg::RAMP_RESET;
      minp_r <= scrp_pkg::MINP_RESET;
      maxp_r <= scrp_pkg::MAXP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scrp_pkg::CFG_RAMP: ramp_r <= cfg_wdata;
        scrp_pkg::CFG_MINP: minp_r <= cfg_wdata;
        scrp_pkg::CFG_MAXP: maxp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    tgt_nxt  = tgt_r;
    dir_nxt  = dir_r;
    ph_nxt   = ph_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    cru_nxt  = cru_r;
    dec_nxt  = dec_r;
    spd_nxt  = spd_r;
    stat_nxt = 1'b0;
    need_nxt = 1'b0;
    k_nxt    = '0;
    move_len = '0;
    n2       = {ramp_r, 1'b0};
    d33      = '0;
    dabs     = '0;
    case (scrp_pkg::req_t'(in_req))
      scrp_pkg::REQ_MOVE: begin
        if (ph_r != scrp_pkg::PH_STOP) begin
          stat_nxt = 1'b1;
        end else if (in_pos != pos_r) begin
          dir_nxt  = $signed(in_pos) > $signed(pos_r);
          move_len = dir_nxt ? (in_pos - pos_r) : (pos_r - in_pos);
          if (move_len > PW'(n2)) begin
            acc_nxt = ramp_r;
            cru_nxt = move_len - PW'(n2);
            dec_nxt = ramp_r;
          end else begin
            dec_nxt = move_len[CW:1];
            cru_nxt = '0;
            acc_nxt = CW'(move_len[CW:0] - {1'b0, move_len[CW:1]});
          end
          ph_nxt   = scrp_pkg::PH_ACCEL;
          step_nxt = SW'(1);
          tgt_nxt  = in_pos;
          need_nxt = 1'b1;
          k_nxt    = CW'(1);
        end
      end
      scrp_pkg::REQ_PULSE: begin
        if (ph_r != scrp_pkg::PH_STOP) begin
          pos_nxt  = dir_r ? (pos_r + 1'b1) : (pos_r - 1'b1);
          step_nxt = step_r + 1'b1;
          d33      = {pos_nxt[PW-1], pos_nxt} - {tgt_r[PW-1], tgt_r};
          dabs     = d33[PW] ? (~d33 + 1'b1) : d33;
          if (ph_r == scrp_pkg::PH_ACCEL) begin
            if (step_nxt > SW'(acc_r)) begin
              step_nxt = SW'(1);
              if (dec_r == '0) begin
                ph_nxt = scrp_pkg::PH_STOP;
              end else if (dabs > (PW+1)'(dec_r)) begin
                ph_nxt  = scrp_pkg::PH_CRUISE;
                spd_nxt = SPD_W'(SPEED_FULL);
              end else begin
                ph_nxt = scrp_pkg::PH_DECEL;
              end
            end else begin
              need_nxt = 1'b1;
              k_nxt    = step_nxt[CW-1:0];
            end
          end
          if (ph_nxt == scrp_pkg::PH_CRUISE && step_nxt > SW'(cru_r)) begin
            step_nxt = SW'(1);
            ph_nxt   = scrp_pkg::PH_DECEL;
          end
          if (ph_nxt == scrp_pkg::PH_DECEL) begin
            if (step_nxt > SW'(dec_r)) begin
              ph_nxt = scrp_pkg::PH_STOP;
            end else begin
              need_nxt = 1'b1;
              k_nxt    = dec_r - step_nxt[CW-1:0] + 1'b1;
            end
          end
          if (ph_nxt == scrp_pkg::PH_STOP) begin
            step_nxt = '0;
            acc_nxt  = '0;
            cru_nxt  = '0;
            dec_nxt  = '0;
            spd_nxt  = '0;
            need_nxt = 1'b0;
          end
        end
      end
      scrp_pkg::REQ_STOP: begin
        ph_nxt   = scrp_pkg::PH_STOP;
        step_nxt = '0;
        acc_nxt  = '0;
        cru_nxt  = '0;
        dec_nxt  = '0;
        spd_nxt  = '0;
      end
      scrp_pkg::REQ_PRESET: begin
        pos_nxt = in_pos;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tgt_r  <= '0;
      dir_r  <= 1'b1;
      ph_r   <= scrp_pkg::PH_STOP;
      step_r <= '0;
      acc_r  <= '0;
      cru_r  <= '0;
      dec_r  <= '0;
      spd_r  <= '0;
      stat_r <= 1'b0;
      need_r <= 1'b0;
      k_r    <= '0;
    end else if (cmd.apply) begin
      pos_r  <= pos_nxt;
      tgt_r  <= tgt_nxt;
      dir_r  <= dir_nxt;
      ph_r   <= ph_nxt;
      step_r <= step_nxt;
      acc_r  <= acc_nxt;
      cru_r  <= cru_nxt;
      dec_r  <= dec_nxt;
      spd_r  <= spd_nxt;
      stat_r <= stat_nxt;
      need_r <= need_nxt;
      k_r    <= k_nxt;
    end else if (cmd.spd_load) begin
      spd_r <= rom_data;
    end
  end

  assign diff = (maxp_r >= minp_r) ? (maxp_r - minp_r) : (minp_r - maxp_r);

  assign rel_prod = (2*PROD_W+2)'(prod_r) * (2*PROD_W+2)'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= PROD_W'(diff) * PROD_W'(spd_r);
    if (cmd.div_rel) rel_q_r <= rel_prod[RSH+CW-1:RSH];
  end

  assign div_start = cmd.div_idx;
  assign div_dvd   = scrp_pkg::DIV_W'({k_r, {PHASE_BITS{1'b0}}});
  assign div_dvs   = ramp_r;

  scrp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign rom_addr = (div_q > IDX_MAX) ? AW'(IDX_MAX) : div_q[AW-1:0];

  scrp_rom #(
    .PHASE_BITS (PHASE_BITS),
    .SPEED_FULL (SPEED_FULL)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign reload = (maxp_r >= minp_r) ? (maxp_r - rel_q_r)
                                     : (maxp_r + rel_q_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= {5'b00000,
                (ph_r != scrp_pkg::PH_STOP),
                reload,
                scrp_pkg::SPD_OUT_W'(spd_r),
                dir_r,
                ph_r,
                pos_r,
                stat_r};
    end
  end

  assign out_tdata        = out_r;
  assign sts.need_lookup  = need_r;
  assign sts.div_busy     = div_busy;

endmodule

### rtl/scrp_checker.sv
module scrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic [71:0] out_tdata
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in work");

  a_pulse_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[66] == (out_tdata[34:33] != 2'd0)))
    else $error("pulse_enable disagrees with phase");

  a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[34:33] != 2'd0))
    else $error("refused move reported while stopped");

  a_stop_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[34:33] == 2'd0)) |-> (out_tdata[49:36] == 14'd0))
    else $error("nonzero speed while stopped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind stepper_cosine_ramp_profiler_core scrp_checker u_chk (.*);

### tb/stepper_cosine_ramp_profiler_core_tb.sv
`timescale 1ns / 1ps

module stepper_cosine_ramp_profiler_core_tb;

  localparam int WDOG_LIMIT = 20000;
  localparam int SETTLE = 100;

  localparam logic [15:0] RAMPS [7] = '{16'd200, 16'd3, 16'd0, 16'd1, 16'd17, 16'd65535,
                                        16'd40};
  localparam logic [15:0] MINPS [7] = '{16'd499, 16'd0, 16'd65535, 16'd100, 16'd65535,
                                        16'd0, 16'd1234};
  localparam logic [15:0] MAXPS [7] = '{16'd19999, 16'd65535, 16'd0, 16'd100, 16'd65535,
                                        16'd0, 16'd777};

  typedef struct {
    scrp_pkg::req_t req;
    logic [31:0]    val;
  } cmd_t;

  typedef struct {
    logic        status;
    logic [31:0] pos;
    logic [1:0]  ph;
    logic        dir;
    logic [13:0] spd;
    logic [15:0] reload;
    logic        pen;
  } motion_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = scrp_pkg::CFG_RAMP;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = scrp_pkg::REQ_MOVE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  cmd_t    pending_cmds[$];
  motion_t expected_motion[$];
  int      send_idle_pct = 26;
  int      recv_idle_pct = 73;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      n_cmds = 0;

  logic [15:0] cosine_tab[1025];

  // predictor state
  logic [15:0]       p_ramp, p_minp, p_maxp;
  logic [31:0]       p_pos, p_tgt;
  logic              p_dir;
  scrp_pkg::phase_t  p_ph;
  logic [32:0]       p_step;
  logic [15:0]       p_acc, p_dec;
  logic [32:0]       p_cruise;
  logic [13:0]       p_spd;

  stepper_cosine_ramp_profiler_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [15:0] cosine_speed(int unsigned i);
    logic [63:0] x, x2, term, acc, s2, v, ii;
    ii = 64'(i);
    x = (((64'h3243F6A8885A308D >> 32) * ii) << 21)
        + (((64'h3243F6A8885A308D & 64'hFFFFFFFF) * ii) >> 11);
    x2 = q60_mul(x, x);
    term = x;
    acc = x;
    for (int n = 1; n <= 13; n++) begin
      term = q60_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    s2 = q60_mul(acc, acc);
    if (s2 > 64'h1000000000000000) s2 = 64'h1000000000000000;
    v = ((64'd10000 * (s2 >> 32)) << 12) + ((64'd10000 * (s2 & 64'hFFFFFFFF)) >> 20);
    v = (v + 64'd256) >> 40;
    if (v > 64'd10000) v = 64'd10000;
    return v[15:0];
  endfunction

  function automatic logic [13:0] ramp_speed(logic [32:0] k);
    logic [63:0] idx;
    if (p_ramp == 0) idx = 1024;
    else idx = (64'(k) << 10) / 64'(p_ramp);
    if (idx > 1024) idx = 1024;
    return cosine_tab[idx][13:0];
  endfunction

  function automatic logic [15:0] reload_of(logic [13:0] s);
    if (p_maxp >= p_minp)
      return p_maxp - 16'((64'(p_maxp - p_minp) * 64'(s)) / 64'd10000);
    return p_maxp + 16'((64'(p_minp - p_maxp) * 64'(s)) / 64'd10000);
  endfunction

  task automatic halt_motor();
    p_ph = scrp_pkg::PH_STOP;
    p_acc = '0;
    p_cruise = '0;
    p_dec = '0;
    p_step = '0;
    p_spd = '0;
  endtask

  task automatic predict_motion(scrp_pkg::req_t r, logic [31:0] v);
    motion_t m;
    logic signed [32:0] c, t, gap;
    logic [32:0] d, n2;
    m.status = 1'b0;
    case (r)
      scrp_pkg::REQ_MOVE: begin
        if (p_ph != scrp_pkg::PH_STOP) m.status = 1'b1;
        else if (v != p_pos) begin
          c = {p_pos[31], p_pos};
          t = {v[31], v};
          p_dir = t > c;
          d = (t > c) ? 33'(t - c) : 33'(c - t);
          n2 = 33'(p_ramp) * 2;
          if (d > n2) begin
            p_acc = p_ramp;
            p_cruise = d - n2;
            p_dec = p_ramp;
          end else begin
            p_dec = 16'(d / 2);
            p_cruise = '0;
            p_acc = 16'(d - d / 2);
          end
          p_ph = scrp_pkg::PH_ACCEL;
          p_step = 1;
          p_tgt = v;
          p_spd = ramp_speed(1);
        end
      end
      scrp_pkg::REQ_PULSE: begin
        if (p_ph != scrp_pkg::PH_STOP) begin
          p_pos = p_dir ? p_pos + 1 : p_pos - 1;
          p_step = p_step + 1;
          if (p_ph == scrp_pkg::PH_ACCEL) begin
            if (p_step > 33'(p_acc)) begin
              p_step = 1;
              gap = $signed({p_pos[31], p_pos}) - $signed({p_tgt[31], p_tgt});
              if (gap < 0) gap = -gap;
              if (p_dec == 0) p_ph = scrp_pkg::PH_STOP;
              else if (33'(gap) > 33'(p_dec)) begin
                p_ph = scrp_pkg::PH_CRUISE;
                p_spd = 14'd10000;
              end else p_ph = scrp_pkg::PH_DECEL;
            end else p_spd = ramp_speed(p_step);
          end
          if (p_ph == scrp_pkg::PH_CRUISE && p_step > p_cruise) begin
            p_step = 1;
            p_ph = scrp_pkg::PH_DECEL;
          end
          if (p_ph == scrp_pkg::PH_DECEL) begin
            if (p_step > 33'(p_dec)) p_ph = scrp_pkg::PH_STOP;
            else p_spd = ramp_speed(33'(p_dec) - p_step + 1);
          end
          if (p_ph == scrp_pkg::PH_STOP) halt_motor();
        end
      end
      scrp_pkg::REQ_STOP: halt_motor();
      default: p_pos = v;
    endcase
    m.pos = p_pos;
    m.ph = p_ph;
    m.dir = p_dir;
    m.spd = p_spd;
    m.reload = reload_of(p_spd);
    m.pen = p_ph != scrp_pkg::PH_STOP;
    expected_motion.push_back(m);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_motion(scrp_pkg::req_t'(in_tuser), in_tdata);
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= c.req;
        in_tdata <= c.val;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_motion.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          motion_t e;
          e = expected_motion.pop_front();
          if (out_tdata[0] !== e.status || out_tdata[32:1] !== e.pos
              || out_tdata[34:33] !== e.ph || out_tdata[35] !== e.dir
              || out_tdata[49:36] !== e.spd || out_tdata[65:50] !== e.reload
              || out_tdata[66] !== e.pen || out_tdata[71:67] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("exp st=%0d pos=%h ph=%0d dir=%0d spd=%0d rel=%0d pen=%0d got %h",
                       e.status, e.pos, e.ph, e.dir, e.spd, e.reload, e.pen, out_tdata);
          end
        end
      end
      out_tready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_cmd(scrp_pkg::req_t r, logic [31:0] v);
    cmd_t c;
    c.req = r;
    c.val = v;
    pending_cmds.push_back(c);
    n_cmds++;
  endtask

  task automatic push_pulses(int n);
    for (int i = 0; i < n; i++) push_cmd(scrp_pkg::REQ_PULSE, $urandom);
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_motion.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(scrp_pkg::cfg_idx_t idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      scrp_pkg::CFG_RAMP: p_ramp = v;
      scrp_pkg::CFG_MINP: p_minp = v;
      scrp_pkg::CFG_MAXP: p_maxp = v;
      default: ;
    endcase
  endtask

  task automatic random_traffic(int goal);
    int sel, span, d, np;
    logic [31:0] base;
    while (n_cmds < goal) begin
      sel = $urandom_range(0, 9);
      span = (32'(p_ramp) * 2 + 20 > 150) ? 150 : 32'(p_ramp) * 2 + 20;
      base = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 4000)) - 2000;
      d = $urandom_range(0, span) - span / 2;
      np = (d < 0) ? -d : d;
      if (sel <= 6) begin
        push_cmd(scrp_pkg::REQ_PRESET, base);
        push_cmd(scrp_pkg::REQ_MOVE, base + d);
        if ($urandom_range(0, 3) == 0) begin
          push_pulses(np / 2);
          if ($urandom_range(0, 1)) push_cmd(scrp_pkg::REQ_MOVE, $urandom);
          else push_cmd(scrp_pkg::REQ_PRESET, $urandom);
          push_pulses(np - np / 2 + $urandom_range(0, 3));
        end else begin
          push_pulses(np + $urandom_range(0, 3));
        end
      end else if (sel == 7) begin
        push_cmd(scrp_pkg::REQ_PRESET, base);
        push_cmd(scrp_pkg::REQ_MOVE, base + d);
        push_pulses($urandom_range(0, np));
        push_cmd(scrp_pkg::REQ_STOP, $urandom);
      end else begin
        for (int i = 0; i < 5; i++)
          push_cmd(scrp_pkg::req_t'($urandom_range(0, 3)), $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i <= 1024; i++) cosine_tab[i] = cosine_speed(i);
    p_ramp = scrp_pkg::RAMP_RESET;
    p_minp = scrp_pkg::MINP_RESET;
    p_maxp = scrp_pkg::MAXP_RESET;
    p_pos = '0;
    p_tgt = '0;
    p_dir = 1'b1;
    halt_motor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    push_cmd(scrp_pkg::REQ_PULSE, 32'h0);
    push_cmd(scrp_pkg::REQ_MOVE, 32'h0);
    push_cmd(scrp_pkg::REQ_MOVE, 32'd5);
    push_cmd(scrp_pkg::REQ_MOVE, 32'hFFFFFFFF);
    push_pulses(2);
    push_cmd(scrp_pkg::REQ_PRESET, 32'h7FFFFFFF);
    push_pulses(4);
    push_cmd(scrp_pkg::REQ_PULSE, 32'h0);
    push_cmd(scrp_pkg::REQ_PRESET, 32'h7FFFFFFE);
    push_cmd(scrp_pkg::REQ_MOVE, 32'h80000000);
    push_pulses(3);
    push_cmd(scrp_pkg::REQ_STOP, 32'hFFFFFFFF);
    push_cmd(scrp_pkg::REQ_PRESET, 32'h80000000);
    push_cmd(scrp_pkg::REQ_MOVE, 32'h7FFFFFFF);
    push_cmd(scrp_pkg::REQ_PRESET, 32'hAAAAAAAA);
    push_cmd(scrp_pkg::REQ_STOP, 32'h55555555);
    push_cmd(scrp_pkg::REQ_PRESET, 32'h0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      send_idle_pct = (ph < 3) ? 26 : (ph < 5) ? 73 : 0;
      recv_idle_pct = (ph < 3) ? 73 : (ph < 5) ? 26 : 0;
      write_reg(scrp_pkg::CFG_RAMP, RAMPS[ph]);
      write_reg(scrp_pkg::CFG_MINP, MINPS[ph]);
      write_reg(scrp_pkg::CFG_MAXP, MAXPS[ph]);
      if (ph == 1) write_reg(scrp_pkg::cfg_idx_t'(2'd3), 16'hFFFF);
      push_pulses(30);
      push_cmd(scrp_pkg::REQ_STOP, $urandom);
      random_traffic(n_cmds + 175);
      // leave a move running across the register change
      push_cmd(scrp_pkg::REQ_PRESET, 32'd1000);
      push_cmd(scrp_pkg::REQ_MOVE, 32'd1060);
      push_pulses(20);
      drain();
    end

    if (mismatches == 0 && expected_motion.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
